@@ rtl/tid_pkg.sv @@
// Package for the Thumb instruction decoder: operation codes and the decoded result type.
// No dependencies.
package tid_pkg;

  localparam logic [6:0] OP_UNDEF = 7'd0, OP_SUBR = 7'd1, OP_ADDR = 7'd2, OP_SUBI3 = 7'd3,
    OP_ADDI3 = 7'd4, OP_LSLI = 7'd5, OP_LSRI = 7'd6, OP_ASRI = 7'd7, OP_MOVI = 7'd8,
    OP_CMPI = 7'd9, OP_ADDI8 = 7'd10, OP_SUBI8 = 7'd11, OP_AND = 7'd12,
    OP_ADDHI = 7'd28, OP_CMPHI = 7'd29, OP_MOVR = 7'd30, OP_BLXR = 7'd31, OP_BXR = 7'd32,
    OP_LDRLIT = 7'd33, OP_STRR = 7'd34, OP_LDRI = 7'd42, OP_STRI = 7'd43, OP_LDRBI = 7'd44,
    OP_STRBI = 7'd45, OP_LDRHI = 7'd46, OP_STRHI = 7'd47, OP_LDRSP = 7'd48,
    OP_STRSP = 7'd49, OP_ADRPC = 7'd50, OP_ADDSPI = 7'd51, OP_ADDSPSP = 7'd52,
    OP_SUBSPSP = 7'd53, OP_PUSHL = 7'd54, OP_POPL = 7'd55, OP_NOPH = 7'd56,
    OP_SXTHW = 7'd61, OP_REVW = 7'd65, OP_REV16W = 7'd66, OP_REVSHW = 7'd67,
    OP_BKPTI = 7'd68, OP_LDMIA = 7'd69, OP_STMIA = 7'd70, OP_UDFI = 7'd71,
    OP_SVCI = 7'd72, OP_BCOND = 7'd73, OP_BUNC = 7'd74, OP_BLW = 7'd75;

  localparam logic [3:0] COND_AL = 4'd14;

  typedef struct packed {
    logic [6:0]  op_code;
    logic [3:0]  dest_reg;
    logic [3:0]  first_src_reg;
    logic [3:0]  second_src_reg;
    logic [31:0] immediate;
    logic [3:0]  condition;
    logic [15:0] register_list;
    logic [2:0]  length_bytes;
    logic [31:0] raw_word;
    logic [31:0] insn_addr;
  } dec_t;

endpackage

@@ rtl/tid_if.sv @@
// Valid/ready channel interfaces for the decoder's input and result beats.
// Depends on tid_pkg.
interface tid_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_half;
  logic [15:0] second_half;
  logic [31:0] fetch_addr;
  modport source (output valid, first_half, second_half, fetch_addr, input ready);
  modport sink (input valid, first_half, second_half, fetch_addr, output ready);
endinterface

interface tid_out_if;
  logic          valid;
  logic          ready;
  tid_pkg::dec_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/tid_decode.sv @@
// Combinational Thumb decode of one registered instruction.
// Depends on tid_pkg.
module tid_decode (
  input  logic [15:0]   w0,
  input  logic [15:0]   w1,
  input  logic [31:0]   addr,
  output tid_pkg::dec_t dec
);

  logic       wide;
  logic [2:0] lo3, mid3, r8;
  logic [3:0] top4;
  logic       s, i1, i2;

  assign wide = (w0[15:11] == 5'h1D) || (w0[15:11] == 5'h1E) || (w0[15:11] == 5'h1F);
  assign lo3  = w0[2:0];
  assign mid3 = w0[5:3];
  assign r8   = w0[10:8];
  assign top4 = w0[15:12];
  assign s    = w0[10];
  assign i1   = ~(w1[13] ^ s);
  assign i2   = ~(w1[11] ^ s);

  always_comb begin
    dec                = '0;
    dec.condition      = tid_pkg::COND_AL;
    dec.length_bytes   = wide ? 3'd4 : 3'd2;
    dec.raw_word       = wide ? {w0, w1} : {16'h0, w0};
    dec.insn_addr      = addr;
    if (wide) begin
      if (w0[15:11] == 5'h1E && w1[15] && w1[12]) begin
        dec.immediate = {{8{s}}, i1, i2, w0[9:0], w1[10:0], 1'b0};
        dec.op_code   = w1[14] ? tid_pkg::OP_BLW : tid_pkg::OP_BUNC;
      end
    end else if (w0[15:11] == 5'b00011) begin
      dec.first_src_reg = {1'b0, mid3};
      dec.dest_reg      = {1'b0, lo3};
      if (!w0[10]) begin
        dec.second_src_reg = {1'b0, w0[8:6]};
        dec.op_code = w0[9] ? tid_pkg::OP_SUBR : tid_pkg::OP_ADDR;
      end else begin
        dec.immediate = {29'h0, w0[8:6]};
        dec.op_code = w0[9] ? tid_pkg::OP_SUBI3 : tid_pkg::OP_ADDI3;
      end
    end else if (w0[15:13] == 3'b000) begin
      dec.second_src_reg = {1'b0, mid3};
      dec.dest_reg       = {1'b0, lo3};
      dec.immediate      = {27'h0, w0[10:6]};
      dec.op_code = tid_pkg::OP_LSLI + {5'h0, w0[12:11]};
    end else if (w0[15:13] == 3'b001) begin
      dec.dest_reg      = {1'b0, r8};
      dec.first_src_reg = {1'b0, r8};
      dec.immediate     = {24'h0, w0[7:0]};
      dec.op_code       = tid_pkg::OP_MOVI + {5'h0, w0[12:11]};
    end else if (w0[15:10] == 6'b010000) begin
      dec.second_src_reg = {1'b0, mid3};
      dec.dest_reg       = {1'b0, lo3};
      dec.first_src_reg  = {1'b0, lo3};
      dec.op_code        = tid_pkg::OP_AND + {3'h0, w0[9:6]};
    end else if (w0[15:10] == 6'b010001) begin
      dec.second_src_reg = w0[6:3];
      unique case (w0[9:8])
        2'd0: begin
          dec.first_src_reg = {w0[7], lo3};
          dec.dest_reg      = {w0[7], lo3};
          dec.op_code       = tid_pkg::OP_ADDHI;
        end
        2'd1: begin
          dec.first_src_reg = {w0[7], lo3};
          dec.op_code       = tid_pkg::OP_CMPHI;
        end
        2'd2: begin
          dec.dest_reg = {w0[7], lo3};
          dec.op_code  = tid_pkg::OP_MOVR;
        end
        default: dec.op_code = w0[7] ? tid_pkg::OP_BLXR : tid_pkg::OP_BXR;
      endcase
    end else if (w0[15:11] == 5'b01001) begin
      dec.op_code   = tid_pkg::OP_LDRLIT;
      dec.dest_reg  = {1'b0, r8};
      dec.immediate = {22'h0, w0[7:0], 2'b00};
    end else if (top4 == 4'h5) begin
      dec.second_src_reg = {1'b0, w0[8:6]};
      dec.first_src_reg  = {1'b0, mid3};
      dec.dest_reg       = {1'b0, lo3};
      dec.op_code        = tid_pkg::OP_STRR + {4'h0, w0[11:9]};
    end else if (top4 == 4'h6 || top4 == 4'h7 || top4 == 4'h8) begin
      dec.first_src_reg = {1'b0, mid3};
      dec.dest_reg      = {1'b0, lo3};
      if (top4 == 4'h6) begin
        dec.immediate = {25'h0, w0[10:6], 2'b00};
        dec.op_code   = w0[11] ? tid_pkg::OP_LDRI : tid_pkg::OP_STRI;
      end else if (top4 == 4'h7) begin
        dec.immediate = {27'h0, w0[10:6]};
        dec.op_code   = w0[11] ? tid_pkg::OP_LDRBI : tid_pkg::OP_STRBI;
      end else begin
        dec.immediate = {26'h0, w0[10:6], 1'b0};
        dec.op_code   = w0[11] ? tid_pkg::OP_LDRHI : tid_pkg::OP_STRHI;
      end
    end else if (top4 == 4'h9 || top4 == 4'hA) begin
      dec.dest_reg  = {1'b0, r8};
      dec.immediate = {22'h0, w0[7:0], 2'b00};
      if (top4 == 4'h9) dec.op_code = w0[11] ? tid_pkg::OP_LDRSP : tid_pkg::OP_STRSP;
      else dec.op_code = w0[11] ? tid_pkg::OP_ADDSPI : tid_pkg::OP_ADRPC;
    end else if (top4 == 4'hB) begin
      if (w0[11:7] == 5'b00000) begin
        dec.immediate = {23'h0, w0[6:0], 2'b00};
        dec.op_code   = tid_pkg::OP_ADDSPSP;
      end else if (w0[11:7] == 5'b00001) begin
        dec.immediate = {23'h0, w0[6:0], 2'b00};
        dec.op_code   = tid_pkg::OP_SUBSPSP;
      end else if (w0[11:9] == 3'b010) begin
        dec.op_code       = tid_pkg::OP_PUSHL;
        dec.register_list = {1'b0, w0[8], 6'h0, w0[7:0]};
      end else if (w0[11:9] == 3'b110) begin
        dec.op_code       = tid_pkg::OP_POPL;
        dec.register_list = {w0[8], 7'h0, w0[7:0]};
      end else if (w0[11:8] == 4'hF && w0[3:0] == 4'h0) begin
        dec.op_code = (w0[7:4] < 4'd5) ? tid_pkg::OP_NOPH + {3'h0, w0[7:4]}
                                       : tid_pkg::OP_NOPH;
      end else if (w0[11:8] == 4'h2) begin
        dec.second_src_reg = {1'b0, mid3};
        dec.dest_reg       = {1'b0, lo3};
        dec.op_code        = tid_pkg::OP_SXTHW + {5'h0, w0[7:6]};
      end else if (w0[11:8] == 4'hA) begin
        if (w0[7:6] != 2'd2) begin
          dec.second_src_reg = {1'b0, mid3};
          dec.dest_reg       = {1'b0, lo3};
          dec.op_code = (w0[7:6] == 2'd0) ? tid_pkg::OP_REVW :
                        (w0[7:6] == 2'd1) ? tid_pkg::OP_REV16W : tid_pkg::OP_REVSHW;
        end
      end else if (w0[11:8] == 4'hE) begin
        dec.op_code   = tid_pkg::OP_BKPTI;
        dec.immediate = {24'h0, w0[7:0]};
      end
    end else if (top4 == 4'hC) begin
      dec.first_src_reg = {1'b0, r8};
      dec.register_list = {8'h0, w0[7:0]};
      dec.op_code       = w0[11] ? tid_pkg::OP_LDMIA : tid_pkg::OP_STMIA;
    end else if (top4 == 4'hD) begin
      if (w0[11:8] == 4'hE) begin
        dec.op_code   = tid_pkg::OP_UDFI;
        dec.immediate = {24'h0, w0[7:0]};
      end else if (w0[11:8] == 4'hF) begin
        dec.op_code   = tid_pkg::OP_SVCI;
        dec.immediate = {24'h0, w0[7:0]};
      end else begin
        dec.op_code   = tid_pkg::OP_BCOND;
        dec.condition = w0[11:8];
        dec.immediate = {{23{w0[7]}}, w0[7:0], 1'b0};
      end
    end else if (w0[15:11] == 5'b11100) begin
      dec.op_code   = tid_pkg::OP_BUNC;
      dec.immediate = {{20{w0[10]}}, w0[10:0], 1'b0};
    end
  end

endmodule

@@ rtl/thumb_instruction_decoder_top.sv @@
// Thumb instruction decoder: an input register feeds a combinational decode,
// whose result goes to a result register. Throughput one instruction per cycle
// while the output does not stall; a skid slot takes one decoded beat in a stall.
// Synchronous active-low reset empties both registers and the skid slot;
// payload is not reset. Depends on tid_pkg, tid_if and tid_decode.
module thumb_instruction_decoder_top (
  input logic   clk,
  input logic   rst_n,
  tid_in_if.sink    in_ch,
  tid_out_if.source out_ch
);

  // Input register stage.
  logic        s1_valid_r;
  logic [15:0] w0_r, w1_r;
  logic [31:0] addr_r;
  logic        s1_adv;

  // Result register and skid slot.
  logic          out_valid_r, skid_valid_r;
  tid_pkg::dec_t out_data_r, skid_data_r, dec;

  tid_decode u_dec (.w0(w0_r), .w1(w1_r), .addr(addr_r), .dec(dec));

  // Advance stage 1 whenever the skid slot is free: it can always absorb one beat.
  assign s1_adv      = !skid_valid_r;
  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      w0_r   <= in_ch.first_half;
      w1_r   <= in_ch.second_half;
      addr_r <= in_ch.fetch_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= in_ch.valid;
      if (!out_valid_r || out_ch.ready) begin
        // Output free: take the skid beat first, else the fresh decode.
        out_valid_r  <= skid_valid_r || (s1_valid_r && s1_adv);
        skid_valid_r <= 1'b0;
      end else if (s1_valid_r && s1_adv) begin
        // Output stalled: park the fresh decode in the skid slot.
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ch.ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : dec;
    end else if (s1_adv) begin
      skid_data_r <= dec;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

`ifndef ASSERT_OFF
  a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid full with empty output");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r && $stable(out_data_r))
    else $error("result dropped under stall");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.length_bytes == 3'd2 || out_data_r.length_bytes == 3'd4))
    else $error("bad length");
`endif

endmodule
